[hw/rtl/lsps_pkg.sv]
// ----------------------------------------------------------------------------
// Least-squares partition select package
// Command and error codes, and loss widths, used by the top module and the loss accumulator.
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int unsigned LossW   = 44;
  localparam int unsigned OutLossW = 43;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned ObsW    = 7;

  localparam logic [1:0] CMD_RUN    = 2'd0;
  localparam logic [1:0] CMD_CAND   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_NO_RUNS = 2'd1;
  localparam logic [1:0] ERR_LENGTH  = 2'd2;

  localparam logic [LossW-1:0] LOSS_MAX = {LossW{1'b1}};
  localparam logic [IdxW-1:0]  CAND_MAX = {IdxW{1'b1}};

  // Control of the loss datapath for one pair.
  typedef struct packed {
    logic clear;
    logic valid;
    logic same;
  } loss_ctrl_t;

endpackage

[hw/rtl/lsps_label_buf.sv]
// ----------------------------------------------------------------------------
// Label buffer
// Holds the labels of the vector being received; two registered read ports.
// ----------------------------------------------------------------------------
module lsps_label_buf #(
  parameter int unsigned MAX_OBS = 64
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(MAX_OBS)-1:0] wr_addr_i,
  input  logic [15:0]                wr_data_i,
  input  logic [$clog2(MAX_OBS)-1:0] rd_a_addr_i,
  input  logic [$clog2(MAX_OBS)-1:0] rd_b_addr_i,
  output logic [15:0]                rd_a_data_o,
  output logic [15:0]                rd_b_data_o
);

  logic [15:0] mem [MAX_OBS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= mem[rd_a_addr_i];
    rd_b_data_o <= mem[rd_b_addr_i];
  end

endmodule

[hw/rtl/lsps_pair_mem.sv]
// ----------------------------------------------------------------------------
// Pair count memory
// One write port and one registered read port over all observation pairs.
// ----------------------------------------------------------------------------
module lsps_pair_mem #(
  parameter int unsigned DEPTH      = 4096,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [COUNT_BITS-1:0]    wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [COUNT_BITS-1:0]    rd_data_o
);

  logic [COUNT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

[hw/rtl/lsps_loss_acc.sv]
// ----------------------------------------------------------------------------
// Loss accumulator
// Difference, square and saturating sum of one pair term per cycle.
// ----------------------------------------------------------------------------
module lsps_loss_acc #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lsps_pkg::loss_ctrl_t    ctrl_i,
  input  logic [COUNT_BITS-1:0]   k_i,
  input  logic [COUNT_BITS-1:0]   c_i,
  output logic                    busy_o,
  output logic [lsps_pkg::LossW-1:0] loss_o
);
  import lsps_pkg::*;

  localparam int unsigned SqW  = 2 * COUNT_BITS;
  localparam int unsigned SumW = ((SqW > LossW) ? SqW : LossW) + 1;

  logic                  d_vld_q, sq_vld_q;
  logic [COUNT_BITS-1:0] d_q, d_d;
  logic [SqW-1:0]        sq_q;
  logic [LossW-1:0]      acc_q;
  logic [SumW-1:0]       sum;

  always_comb begin
    if (!ctrl_i.same) begin
      d_d = c_i;
    end else if (k_i >= c_i) begin
      d_d = k_i - c_i;
    end else begin
      d_d = c_i - k_i;
    end
    sum = SumW'(acc_q) + SumW'(sq_q);
  end

  always_ff @(posedge clk_i) begin
    d_q  <= d_d;
    sq_q <= d_q * d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q  <= 1'b0;
      sq_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      d_vld_q  <= ctrl_i.valid;
      sq_vld_q <= d_vld_q;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (sq_vld_q) begin
        acc_q <= (sum > SumW'(LOSS_MAX)) ? LOSS_MAX : sum[LossW-1:0];
      end
    end
  end

  assign busy_o = d_vld_q | sq_vld_q;
  assign loss_o = acc_q;

endmodule

[hw/rtl/cooccurrence_ls_partition_select.sv]
// ----------------------------------------------------------------------------
// Co-occurrence least-squares partition select
// Accumulates pair co-occurrence counts over run vectors, scores candidate
// vectors by their scaled least-squares loss and reports the best one.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                  Moves
//  in        sink       in_valid_i/in_ready_o, command/label/last one label or command
//  out       source     out_valid_o/out_ready_i, best_index etc.  one report
//  cfg       sink       cfg_we_i, cfg_wdata_i                     num_obs write
//
//  A label transfer without the last flag advances the label position. A last
//  label of an accepted run vector walks all n*n pairs, a candidate all
//  n*(n-1)/2 pairs, one pair per cycle, candidates through the loss pipeline,
//  and then drains; a one-label candidate goes straight to the drain. After
//  reset and after a clear the pair count memory is swept to zero, one entry
//  a cycle, with in_ready_o low. A finish report waits in the output register;
//  while it waits, every further transfer is held off until the report is taken.
// ----------------------------------------------------------------------------
module cooccurrence_ls_partition_select #(
  parameter int unsigned MAX_OBS    = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsps_pkg::ObsW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [15:0]                   label_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsps_pkg::IdxW-1:0]     best_index_o,
  output logic [lsps_pkg::OutLossW-1:0] lowest_loss_o,
  output logic [1:0]                    error_code_o
);
  import lsps_pkg::*;

  localparam int unsigned Depth = MAX_OBS * MAX_OBS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = $clog2(MAX_OBS);
  localparam int unsigned PW    = $clog2(MAX_OBS + 2);
  localparam int unsigned CW    = (PW > ObsW) ? PW : ObsW;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;

  logic [2:0]            state_q, state_d;
  logic [ObsW-1:0]       num_obs_q;
  logic [PW-1:0]         pos_q, pos_d, pos_inc;
  logic [COUNT_BITS-1:0] run_cnt_q, run_cnt_d;
  logic [IdxW-1:0]       cand_cnt_q, cand_cnt_d;
  logic [LossW-1:0]      low_loss_q, low_loss_d;
  logic [IdxW-1:0]       low_pos_q, low_pos_d;
  logic                  fault_q, fault_d;
  logic                  is_cand_q, is_cand_d;
  logic [IW-1:0]         i_q, i_d, j_q, j_d, n_m1_q, n_m1_d;
  logic [AW-1:0]         sweep_q, sweep_d;
  logic                  issue;
  logic                  s1_vld_q, s1_cand_q;
  logic [AW-1:0]         s1_addr_q;
  logic                  out_vld_q, out_vld_d;
  logic [IdxW-1:0]       out_idx_q, out_idx_d;
  logic [OutLossW-1:0]   out_loss_q, out_loss_d;
  logic [1:0]            out_err_q, out_err_d;
  logic                  accept;
  logic [CW-1:0]         n_eff;
  logic [15:0]           lab_a, lab_b;
  logic [COUNT_BITS-1:0] pc_rd;
  logic                  pc_we;
  logic [AW-1:0]         pc_waddr;
  logic [COUNT_BITS-1:0] pc_wdata;
  logic                  same;
  logic                  loss_busy;
  logic [LossW-1:0]      loss;
  loss_ctrl_t            loss_ctrl;
  logic [1:0]            err;
  logic                  walk_last;

  // Register values above MAX_OBS behave as MAX_OBS.
  assign n_eff = (CW'(num_obs_q) > CW'(MAX_OBS)) ? CW'(MAX_OBS) : CW'(num_obs_q);

  assign in_ready_o = (state_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_inc    = (pos_q <= PW'(MAX_OBS)) ? pos_q + 1'b1 : pos_q;
  assign same       = (lab_a == lab_b);
  assign issue      = (state_q == ST_WALK);
  assign walk_last  = (j_q == n_m1_q) &&
                      (is_cand_q ? (i_q == n_m1_q - 1'b1) : (i_q == n_m1_q));

  // Finish report, worked out from the state as it stands.
  always_comb begin
    if (fault_q) begin
      err = ERR_LENGTH;
    end else if (run_cnt_q == '0) begin
      err = ERR_NO_RUNS;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    run_cnt_d  = run_cnt_q;
    cand_cnt_d = cand_cnt_q;
    low_loss_d = low_loss_q;
    low_pos_d  = low_pos_q;
    fault_d    = fault_q;
    is_cand_d  = is_cand_q;
    i_d        = i_q;
    j_d        = j_q;
    n_m1_d     = n_m1_q;
    sweep_d    = sweep_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_idx_d  = out_idx_q;
    out_loss_d = out_loss_q;
    out_err_d  = out_err_q;
    loss_ctrl  = '{clear: 1'b0, valid: s1_vld_q && s1_cand_q, same: same};

    unique case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_CLEAR: begin
              pos_d      = '0;
              run_cnt_d  = '0;
              cand_cnt_d = '0;
              low_loss_d = LOSS_MAX;
              low_pos_d  = '0;
              fault_d    = 1'b0;
              sweep_d    = '0;
              state_d    = ST_CLEAR;
            end
            CMD_FINISH: begin
              out_vld_d = 1'b1;
              out_err_d = err;
              if (err != ERR_OK || cand_cnt_q == '0) begin
                out_idx_d  = IdxW'(1);
                out_loss_d = '0;
              end else begin
                out_idx_d  = low_pos_q + 1'b1;
                out_loss_d = low_loss_q[OutLossW-1:0];
              end
            end
            default: begin
              pos_d = pos_inc;
              if (last_i) begin
                pos_d     = '0;
                is_cand_d = (command_i == CMD_CAND);
                n_m1_d    = IW'(n_eff - 1'b1);
                i_d       = '0;
                j_d       = (command_i == CMD_CAND) ? IW'(1) : '0;
                loss_ctrl.clear = 1'b1;
                if (n_eff == '0 || CW'(pos_inc) != n_eff) begin
                  fault_d = 1'b1;
                end else if (command_i == CMD_RUN) begin
                  if (run_cnt_q != CountMax) begin
                    state_d = ST_WALK;
                  end
                end else if (cand_cnt_q != CAND_MAX) begin
                  // A one-label candidate has no pairs and scores zero.
                  state_d = (n_eff == CW'(1)) ? ST_DRAIN : ST_WALK;
                end
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_DRAIN;
        end else if (j_q == n_m1_q) begin
          i_d = i_q + 1'b1;
          j_d = is_cand_q ? IW'(i_q + 2'd2) : '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !loss_busy) begin
          state_d = ST_IDLE;
          if (is_cand_q) begin
            if (cand_cnt_q == '0 || loss < low_loss_q) begin
              low_loss_d = loss;
              low_pos_d  = cand_cnt_q;
            end
            cand_cnt_d = cand_cnt_q + 1'b1;
          end else begin
            run_cnt_d = run_cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A clear sweep writes zeros; otherwise run vectors bump (saturating) the count of every pair that shares a label.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      pc_we    = 1'b1;
      pc_waddr = sweep_q;
      pc_wdata = '0;
    end else begin
      pc_we    = s1_vld_q && !s1_cand_q && same && (pc_rd != CountMax);
      pc_waddr = s1_addr_q;
      pc_wdata = pc_rd + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      num_obs_q  <= ObsW'(64);
      pos_q      <= '0;
      run_cnt_q  <= '0;
      cand_cnt_q <= '0;
      low_loss_q <= LOSS_MAX;
      low_pos_q  <= '0;
      fault_q    <= 1'b0;
      is_cand_q  <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      n_m1_q     <= '0;
      sweep_q    <= '0;
      s1_vld_q   <= 1'b0;
      s1_cand_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        num_obs_q <= cfg_wdata_i;
      end
      pos_q      <= pos_d;
      run_cnt_q  <= run_cnt_d;
      cand_cnt_q <= cand_cnt_d;
      low_loss_q <= low_loss_d;
      low_pos_q  <= low_pos_d;
      fault_q    <= fault_d;
      is_cand_q  <= is_cand_d;
      i_q        <= i_d;
      j_q        <= j_d;
      n_m1_q     <= n_m1_d;
      sweep_q    <= sweep_d;
      s1_vld_q   <= issue;
      s1_cand_q  <= is_cand_q;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= AW'(i_q) * AW'(MAX_OBS) + AW'(j_q);
    out_idx_q  <= out_idx_d;
    out_loss_q <= out_loss_d;
    out_err_q  <= out_err_d;
  end

  lsps_label_buf #(
    .MAX_OBS (MAX_OBS)
  ) u_label_buf (
    .clk_i       (clk_i),
    .wr_en_i     (accept && !command_i[1] && pos_q < PW'(MAX_OBS)),
    .wr_addr_i   (IW'(pos_q)),
    .wr_data_i   (label_i),
    .rd_a_addr_i (i_q),
    .rd_b_addr_i (j_q),
    .rd_a_data_o (lab_a),
    .rd_b_data_o (lab_b)
  );

  lsps_pair_mem #(
    .DEPTH      (Depth),
    .COUNT_BITS (COUNT_BITS)
  ) u_pair_mem (
    .clk_i     (clk_i),
    .wr_en_i   (pc_we),
    .wr_addr_i (pc_waddr),
    .wr_data_i (pc_wdata),
    .rd_addr_i (AW'(i_q) * AW'(MAX_OBS) + AW'(j_q)),
    .rd_data_o (pc_rd)
  );

  lsps_loss_acc #(
    .COUNT_BITS (COUNT_BITS)
  ) u_loss_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (loss_ctrl),
    .k_i    (run_cnt_q),
    .c_i    (pc_rd),
    .busy_o (loss_busy),
    .loss_o (loss)
  );

  assign out_valid_o   = out_vld_q;
  assign best_index_o  = out_idx_q;
  assign lowest_loss_o = out_loss_q;
  assign error_code_o  = out_err_q;

  // The label count never passes its saturation point.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_OBS + 1))
    else $error("label position beyond saturation");

  // Pair reads only come back while a vector is being walked or drained.
  a_s1_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("pair data outside a walk");

  // No transfer is taken while the pair memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("ready during clear sweep");

  // A drained walk always returns to idle in the next cycle.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !s1_vld_q && !loss_busy) |=> (state_q == ST_IDLE))
    else $error("drain did not complete");

endmodule
